@@ rtl/joint_command_shaper_assert.svh @@
// assertion macros for the joint command shaper
`ifndef JOINT_COMMAND_SHAPER_ASSERT_SVH
`define JOINT_COMMAND_SHAPER_ASSERT_SVH

// implication checked on every rising edge outside reset
`define JCS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define JCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/jcs_pkg.sv @@
`default_nettype none
package jcs_pkg;

  localparam int unsigned AngleW = 32;
  localparam int unsigned VelW = 31;
  localparam int unsigned AlphaW = 17;
  localparam int unsigned CyclesW = 16;
  localparam int unsigned DtW = 21;
  localparam int unsigned MaxJoints = 7;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_GOAL = 2'd1,
    OP_HOLD = 2'd2,
    OP_SYNC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MAX_VELOCITY = 2'd0,
    REG_SMOOTHING_ALPHA = 2'd1,
    REG_RAMP_CYCLES = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_READ,
    ST_FILT_MUL,
    ST_FILT_DIV,
    ST_FILT_WR,
    ST_RAMP_MUL,
    ST_RAMP_GO,
    ST_RAMP_DIV,
    ST_SLEW,
    ST_OUT
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/jcs_if.sv @@
`default_nettype none
interface jcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic                         arm;
  logic signed [31:0]           joint_a;
  logic signed [31:0]           joint_b;
  logic signed [31:0]           joint_c;
  logic signed [31:0]           joint_d;
  logic signed [31:0]           joint_e;
  logic signed [31:0]           joint_f;
  logic signed [31:0]           joint_g;
  logic [20:0]                  tick_time;
  modport source (output valid, operation, arm, joint_a, joint_b, joint_c, joint_d, joint_e,
    joint_f, joint_g, tick_time, input ready);
  modport sink (input valid, operation, arm, joint_a, joint_b, joint_c, joint_d, joint_e,
    joint_f, joint_g, tick_time, output ready);
endinterface

interface jcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] command_a;
  logic signed [31:0] command_b;
  logic signed [31:0] command_c;
  logic signed [31:0] command_d;
  logic signed [31:0] command_e;
  logic signed [31:0] command_f;
  logic signed [31:0] command_g;
  logic               ramp_active;
  logic               target_valid;
  modport source (output valid, command_a, command_b, command_c, command_d, command_e,
    command_f, command_g, ramp_active, target_valid, input ready);
  modport sink (input valid, command_a, command_b, command_c, command_d, command_e,
    command_f, command_g, ramp_active, target_valid, output ready);
endinterface

interface jcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/joint_command_shaper.sv @@
`default_nettype none
// Joint command shaper: one item at a time, input not ready until the result is taken.
// Sync writes each joint in turn; a tick with no valid target goes straight to the
// result; tick or hold with no ramp slews each joint in turn; a ramp step puts each
// joint through multiply, divider start, the shared bit-serial divider and slew; a
// new goal first passes each joint through the filter write when unfiltered, or
// through read, multiply, divide and write when filtered. The filter divides by
// 65536 with a rounding shift. Per-arm joint state sits in registers
// indexed by a joint counter; the filter and the ramp share one multiplier.
module joint_command_shaper #(
  parameter int unsigned ARMS = 2,
  parameter int unsigned JOINTS = 7
) (
  input  wire logic clk,
  input  wire logic rst,
  jcs_in_if.sink    in_ch,
  jcs_out_if.source out_ch,
  jcs_cfg_if.sink   cfg
);
  localparam int unsigned Slots = ARMS * JOINTS;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned ArmW = (ARMS > 1) ? $clog2(ARMS) : 1;
  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  jcs_pkg::state_t state, state_next;

  // configuration registers
  logic [30:0] max_velocity;
  logic [16:0] smoothing_alpha;
  logic [15:0] ramp_cycles;

  // per-joint and per-arm state
  logic signed [31:0] smoothed [Slots];
  logic signed [31:0] target [Slots];
  logic signed [31:0] rstart [Slots];
  logic signed [31:0] rgoal [Slots];
  logic [15:0] rstep [ARMS];
  logic [15:0] rtotal [ARMS];
  logic [ARMS-1:0] ron;
  logic [ARMS-1:0] hastgt;

  // latched item
  jcs_pkg::op_t op;
  logic [ArmW-1:0] arm;
  logic arm_ok;
  logic signed [31:0] joint_in [jcs_pkg::MaxJoints];
  logic [20:0] dt;

  // working registers
  logic [JW-1:0] jidx;
  logic [SlotW-1:0] slot;
  logic [51:0] limit;
  logic signed [63:0] prod;
  logic neg;
  logic signed [31:0] desired;
  logic ramp_act;
  logic [15:0] rnum;
  logic [16:0] rden;
  logic bypass;
  logic signed [32:0] cur_a;

  jcs_pkg::div_req_t dreq;
  jcs_pkg::div_rsp_t drsp;

  jcs_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic in_fire, out_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state == jcs_pkg::ST_IDLE) && !out_ch.valid;
  assign cfg.ready = 1'b1;

  assign slot = SlotW'(arm * JOINTS + jidx);

  // signed magnitudes of products and quotients
  logic [63:0] prod_mag;
  assign prod_mag = prod[63] ? 64'(-prod) : 64'(prod);

  // rounding offset added before division
  logic [63:0] div_num_filt, div_num_ramp;
  assign div_num_filt = prod_mag + 64'd32768;
  assign div_num_ramp = prod_mag + 64'(rden >> 1);

  // filter quotient by shift, ramp quotient from the divider
  logic [47:0] qmag;
  logic signed [48:0] qsigned;
  assign qmag = (state == jcs_pkg::ST_FILT_DIV) ? 48'(div_num_filt >> 16) : drsp.quo;
  assign qsigned = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  // slew computation on the current joint
  logic signed [33:0] delta;
  logic [33:0] dmag;
  logic signed [31:0] slewed;
  always_comb begin
    delta = 34'(desired) - 34'(smoothed[slot]);
    dmag = delta[33] ? 34'(-delta) : 34'(delta);
    slewed = desired;
    if (52'(dmag) > limit)
      slewed = delta[33] ? 32'(34'(smoothed[slot]) - 34'(limit))
                         : 32'(34'(smoothed[slot]) + 34'(limit));
  end

  logic last_j;
  assign last_j = (jidx == JW'(JOINTS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= jcs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.num = div_num_ramp;
    dreq.den = rden;
    case (state)
      jcs_pkg::ST_IDLE: if (in_fire) state_next = jcs_pkg::ST_LIMIT;
      jcs_pkg::ST_LIMIT: begin
        if (!arm_ok) state_next = jcs_pkg::ST_OUT;
        else if (op == jcs_pkg::OP_GOAL && !bypass) state_next = jcs_pkg::ST_READ;
        else state_next = jcs_pkg::ST_FILT_WR;
      end
      jcs_pkg::ST_READ: state_next = jcs_pkg::ST_FILT_MUL;
      jcs_pkg::ST_FILT_MUL: state_next = jcs_pkg::ST_FILT_DIV;
      jcs_pkg::ST_FILT_DIV: state_next = jcs_pkg::ST_FILT_WR;
      jcs_pkg::ST_FILT_WR: begin
        if (op == jcs_pkg::OP_SYNC) state_next = last_j ? jcs_pkg::ST_OUT : state;
        else if (op == jcs_pkg::OP_GOAL && !bypass && !last_j) state_next = jcs_pkg::ST_READ;
        else if (op == jcs_pkg::OP_GOAL && !last_j) state_next = state;
        else if (!hastgt[arm] && op == jcs_pkg::OP_TICK) state_next = jcs_pkg::ST_OUT;
        else state_next = jcs_pkg::ST_RAMP_MUL;
      end
      jcs_pkg::ST_RAMP_MUL: state_next = ramp_act ? jcs_pkg::ST_RAMP_GO : jcs_pkg::ST_SLEW;
      jcs_pkg::ST_RAMP_GO: begin
        dreq.start = 1'b1;
        state_next = jcs_pkg::ST_RAMP_DIV;
      end
      jcs_pkg::ST_RAMP_DIV: if (drsp.done) state_next = jcs_pkg::ST_SLEW;
      jcs_pkg::ST_SLEW: state_next = last_j ? jcs_pkg::ST_OUT : jcs_pkg::ST_RAMP_MUL;
      jcs_pkg::ST_OUT: if (out_fire) state_next = jcs_pkg::ST_IDLE;
      default: state_next = jcs_pkg::ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= 31'd16777216;
      smoothing_alpha <= 17'd65536;
      ramp_cycles <= 16'd1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        jcs_pkg::REG_MAX_VELOCITY: max_velocity <= cfg.data[30:0];
        jcs_pkg::REG_SMOOTHING_ALPHA: smoothing_alpha <= cfg.data[16:0];
        jcs_pkg::REG_RAMP_CYCLES: ramp_cycles <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      ron <= '0;
      hastgt <= '0;
      for (int i = 0; i < ARMS; i++) begin
        rstep[i] <= '0;
        rtotal[i] <= '0;
      end
      for (int i = 0; i < Slots; i++) begin
        smoothed[i] <= '0;
        target[i] <= '0;
        rstart[i] <= '0;
        rgoal[i] <= '0;
      end
    end else begin
      if (out_fire) out_ch.valid <= 1'b0;
      case (state)
        jcs_pkg::ST_IDLE: if (in_fire) begin
          op <= jcs_pkg::op_t'(in_ch.operation);
          arm_ok <= 32'(in_ch.arm) < ARMS;
          arm <= ArmW'(in_ch.arm);
          joint_in[0] <= in_ch.joint_a;
          joint_in[1] <= in_ch.joint_b;
          joint_in[2] <= in_ch.joint_c;
          joint_in[3] <= in_ch.joint_d;
          joint_in[4] <= in_ch.joint_e;
          joint_in[5] <= in_ch.joint_f;
          joint_in[6] <= in_ch.joint_g;
          dt <= in_ch.tick_time;
          jidx <= '0;
        end
        jcs_pkg::ST_LIMIT: begin
          limit <= 52'((64'(max_velocity) * 64'(dt) + 64'h80000) >> 20);
          bypass <= (smoothing_alpha >= 17'd65536) || !hastgt[arm];
          // arm out of range: all-zero result at once
          if (!arm_ok) out_ch.valid <= 1'b1;
        end
        jcs_pkg::ST_READ: begin
          cur_a <= 33'(joint_in[jidx]) - 33'(target[slot]);
        end
        jcs_pkg::ST_FILT_MUL: ;
        jcs_pkg::ST_FILT_DIV: desired <= 32'(49'(target[slot]) + qsigned);
        jcs_pkg::ST_FILT_WR: begin
          if (op == jcs_pkg::OP_SYNC) begin
            smoothed[slot] <= joint_in[jidx];
            target[slot] <= joint_in[jidx];
            rstart[slot] <= joint_in[jidx];
            rgoal[slot] <= joint_in[jidx];
            if (last_j) begin
              rstep[arm] <= '0;
              rtotal[arm] <= '0;
              ron[arm] <= 1'b0;
              hastgt[arm] <= 1'b1;
            end else jidx <= jidx + JW'(1);
          end else if (op == jcs_pkg::OP_GOAL) begin
            target[slot] <= bypass ? joint_in[jidx] : desired;
            rgoal[slot] <= bypass ? joint_in[jidx] : desired;
            rstart[slot] <= smoothed[slot];
            if (last_j) begin
              hastgt[arm] <= 1'b1;
              rstep[arm] <= '0;
              rtotal[arm] <= (ramp_cycles != 16'd0) ? ramp_cycles : 16'd1;
              ron[arm] <= 1'b1;
              jidx <= '0;
            end else jidx <= jidx + JW'(1);
          end else begin
            if (op == jcs_pkg::OP_HOLD) begin
              ron[arm] <= 1'b0;
              rstep[arm] <= '0;
              rtotal[arm] <= '0;
              for (int j = 0; j < JOINTS; j++) begin
                rstart[SlotW'(arm * JOINTS + j)] <= smoothed[SlotW'(arm * JOINTS + j)];
                rgoal[SlotW'(arm * JOINTS + j)] <= smoothed[SlotW'(arm * JOINTS + j)];
                target[SlotW'(arm * JOINTS + j)] <= smoothed[SlotW'(arm * JOINTS + j)];
              end
              hastgt[arm] <= 1'b1;
            end
            jidx <= '0;
          end
          if (state_next == jcs_pkg::ST_OUT) out_ch.valid <= 1'b1;
          // ramp parameters for this tick
          ramp_act <= (op == jcs_pkg::OP_GOAL) ? 1'b1 : (op == jcs_pkg::OP_HOLD) ? 1'b0 : ron[arm];
          rnum <= (op == jcs_pkg::OP_GOAL) ? 16'd1 : rstep[arm] + 16'd1;
          rden <= (op == jcs_pkg::OP_GOAL) ?
                  ((ramp_cycles != 16'd0) ? {1'b0, ramp_cycles} : 17'd1) :
                  ((rtotal[arm] != 16'd0) ? {1'b0, rtotal[arm]} : 17'd1);
        end
        jcs_pkg::ST_RAMP_MUL: begin
          desired <= target[slot];
        end
        jcs_pkg::ST_RAMP_DIV: if (drsp.done) desired <= 32'(49'(rstart[slot]) + qsigned);
        jcs_pkg::ST_SLEW: begin
          smoothed[slot] <= slewed;
          if (last_j) begin
            out_ch.valid <= 1'b1;
            if (ramp_act) begin
              if (rnum >= rden[15:0] || rden[16]) begin
                ron[arm] <= 1'b0;
                rstep[arm] <= '0;
                rtotal[arm] <= '0;
                for (int j = 0; j < JOINTS; j++)
                  rstart[SlotW'(arm * JOINTS + j)] <= rgoal[SlotW'(arm * JOINTS + j)];
              end else rstep[arm] <= rnum;
            end
          end else jidx <= jidx + JW'(1);
        end
        default: ;
      endcase
    end
  end

  // shared multiplier: filter or ramp product, sign kept aside
  always_ff @(posedge clk) begin
    if (state == jcs_pkg::ST_FILT_MUL) begin
      prod <= 64'(cur_a) * $signed({15'd0, smoothing_alpha});
      neg <= cur_a[32];
    end else if (state == jcs_pkg::ST_RAMP_MUL) begin
      prod <= 64'(33'(rgoal[slot]) - 33'(rstart[slot])) * $signed({16'd0, rnum});
      neg <= rgoal[slot] < rstart[slot];
    end
  end

  // result fields
  logic signed [31:0] cmd [jcs_pkg::MaxJoints];
  always_comb begin
    for (int j = 0; j < jcs_pkg::MaxJoints; j++) begin
      cmd[j] = '0;
      if (j < JOINTS && arm_ok) cmd[j] = smoothed[SlotW'(arm * JOINTS + j)];
    end
  end
  assign out_ch.command_a = cmd[0];
  assign out_ch.command_b = cmd[1];
  assign out_ch.command_c = cmd[2];
  assign out_ch.command_d = cmd[3];
  assign out_ch.command_e = cmd[4];
  assign out_ch.command_f = cmd[5];
  assign out_ch.command_g = cmd[6];
  assign out_ch.ramp_active = arm_ok && ron[arm];
  assign out_ch.target_valid = arm_ok && hastgt[arm];

  logic unused;
  assign unused = cfg.data[31];

`include "joint_command_shaper_assert.svh"
  `JCS_ASSERT_IMP(a_busy_not_ready, clk, rst, state != jcs_pkg::ST_IDLE, !in_ch.ready)
  `JCS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_fire, state == jcs_pkg::ST_LIMIT)
  `JCS_ASSERT_IMP(a_valid_in_out, clk, rst, out_ch.valid,
    state == jcs_pkg::ST_OUT || state == jcs_pkg::ST_IDLE)
endmodule
`default_nettype wire

@@ rtl/jcs_divider.sv @@
`default_nettype none
// unsigned restoring divider, one quotient bit per cycle
module jcs_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jcs_pkg::div_req_t req,
  output jcs_pkg::div_rsp_t      rsp
);
  logic [63:0] num;
  logic [16:0] den;
  logic [17:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem[16:0], num[63]} - {1'b0, den};

  // shift and subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        num <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          num <= {num[62:0], 1'b1};
        end else begin
          rem <= {rem[16:0], num[63]};
          num <= {num[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, num[47:0]};
endmodule
`default_nettype wire
